// ----- design/timer_deadline_queue_unit_assert.svh -----
// Assertion macros shared by the timer deadline queue.
`ifndef TIMER_DEADLINE_QUEUE_UNIT_ASSERT_SVH
`define TIMER_DEADLINE_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tdq_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer deadline queue package
// Sizes, operation codes, sequencer states and the structs between the
// sequencer and the slot cells.
// ----------------------------------------------------------------------------
package tdq_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int TIME_BITS = 64;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    localparam logic [31:0] ROLLOVER_RESET = 32'(60 * 60 * 1000);

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_CANCEL  = 3'd1,
        OP_REFRESH = 3'd2,
        OP_RESET   = 3'd3,
        OP_QUERY   = 3'd4,
        OP_EXPIRE  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_OUT,
        ST_XSTART,
        ST_XSCAN,
        ST_XRES
    } tdq_state_t;

    // Best candidate handed from one cell to the next.
    typedef struct packed {
        logic                 valid;
        logic [SLOT_W-1:0]    slot;
        logic [TIME_BITS-1:0] deadline;
    } scan_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                 we;
        logic [SLOT_W-1:0]    slot;
        logic [TIME_BITS-1:0] deadline;
        logic [31:0]          period;
        logic                 repeat_mark;
        logic                 armed;
        logic                 pend_load;
        logic                 pend_clr;
        logic                 roll;
        logic                 commit;
        logic [TIME_BITS-1:0] now;
    } cell_ctl_t;

    // Contents of one cell as seen by the sequencer.
    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [31:0]          period;
        logic                 repeat_mark;
        logic                 armed;
        logic                 pend;
        logic                 survive;
    } cell_state_t;

endpackage

// ----- design/tdq_cell.sv -----
// ----------------------------------------------------------------------------
// Timer slot cell
// Holds one slot and one stage of the earliest-deadline search chain.
// ----------------------------------------------------------------------------
module tdq_cell import tdq_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SLOT_W-1:0] my_slot,
    input  cell_ctl_t         ctl,
    input  logic              scan_pend,
    input  scan_t             scan_in,
    output scan_t             scan_out,
    output cell_state_t       state
);

    logic [TIME_BITS-1:0] deadline_reg;
    logic [31:0]          period_reg;
    logic                 repeat_reg;
    logic                 armed_reg;
    logic                 pend_reg;
    logic                 fire_reg;
    scan_t                scan_reg;
    scan_t                scan_next;
    logic                 hit;
    logic                 cand;
    logic                 due;

    assign hit = (ctl.slot == my_slot);
    assign due = armed_reg && (ctl.roll || (deadline_reg <= ctl.now));

    always_ff @(posedge aclk) begin
        scan_reg.slot     <= scan_next.slot;
        scan_reg.deadline <= scan_next.deadline;
        if (!aresetn) begin
            armed_reg      <= 1'b0;
            pend_reg       <= 1'b0;
            fire_reg       <= 1'b0;
            scan_reg.valid <= 1'b0;
        end else begin
            if (ctl.we && hit) begin
                armed_reg <= ctl.armed;
            end
            if (ctl.pend_load) begin
                pend_reg <= due;
                fire_reg <= due;
            end else if (ctl.pend_clr && hit) begin
                pend_reg <= 1'b0;
            end
            if (ctl.commit && fire_reg) begin
                if (!repeat_reg) begin
                    armed_reg <= 1'b0;
                end
                fire_reg <= 1'b0;
            end
            scan_reg.valid <= scan_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.we && hit) begin
            deadline_reg <= ctl.deadline;
            period_reg   <= ctl.period;
            repeat_reg   <= ctl.repeat_mark;
        end else if (ctl.commit && fire_reg && repeat_reg) begin
            deadline_reg <= ctl.now + TIME_BITS'(period_reg);
        end
    end

    // Strict compare keeps the lower slot on a tie, since it sits earlier in the chain.
    always_comb begin
        cand = scan_pend ? pend_reg : armed_reg;
        if (cand && (!scan_in.valid || (deadline_reg < scan_in.deadline))) begin
            scan_next.valid    = 1'b1;
            scan_next.slot     = my_slot;
            scan_next.deadline = deadline_reg;
        end else begin
            scan_next = scan_in;
        end
    end

    assign scan_out          = scan_reg;
    assign state.deadline    = deadline_reg;
    assign state.period      = period_reg;
    assign state.repeat_mark = repeat_reg;
    assign state.armed       = armed_reg;
    assign state.pend        = pend_reg;
    assign state.survive     = armed_reg && !(fire_reg && !repeat_reg);

endmodule

// ----- design/timer_deadline_queue_unit.sv -----
// Cancel and refresh finish without a search; add, query and a reset that rewrites
// its slot wait for the search wave that crosses the row of slot cells one cell per cycle.
// Expire, when a slot is armed, runs the wave once per fired slot and once more at the end.
// One request is worked at a time; a finished result waits in the output register.
// Synchronous active-low reset disarms all slots, clears the last time and the
// front flag, and loads the rollover window with one hour in ms.
// ----------------------------------------------------------------------------
// Timer deadline queue
// Bank of timer slots with add, cancel, refresh, reset, query and expire.
// ----------------------------------------------------------------------------
`include "timer_deadline_queue_unit_assert.svh"

module timer_deadline_queue_unit import tdq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_rollover_window_ms,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [3:0]  s_slot_id,
    input  logic [31:0] s_period_ms,
    input  logic        s_recurring,
    input  logic        s_from_now,
    input  logic [63:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic        m_fired,
    output logic [3:0]  m_fired_slot,
    output logic [63:0] m_wait_ms,
    output logic        m_front_changed,
    output logic        m_any_active,
    output logic        m_last
);

    tdq_state_t           state_reg, state_next;
    op_t                  op_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 inrange_reg;
    logic [31:0]          per_reg;
    logic                 rec_reg;
    logic                 fromnow_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [31:0]          window_reg;
    logic [TIME_BITS-1:0] prev_now_reg, prev_now_next;
    logic                 flag_reg, flag_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 scan_pend_reg, scan_pend_next;
    logic                 res_ok_reg, res_ok_next;
    logic                 res_front_reg, res_front_next;
    logic [63:0]          res_wait_reg, res_wait_next;
    logic                 have_prev_reg, have_prev_next;
    logic [SLOT_W-1:0]    prev_slot_reg, prev_slot_next;
    logic                 any_after_reg, any_after_next;

    logic                 m_valid_reg;
    logic                 out_load;
    logic                 out_ok_reg, out_ok_next;
    logic                 out_fired_reg, out_fired_next;
    logic [3:0]           out_slot_reg, out_slot_next;
    logic [63:0]          out_wait_reg, out_wait_next;
    logic                 out_front_reg, out_front_next;
    logic                 out_any_reg, out_any_next;
    logic                 out_last_reg, out_last_next;

    cell_ctl_t            ctl;
    scan_t                scan_link [NUM_SLOTS+1];
    cell_state_t          cells [NUM_SLOTS];
    cell_state_t          sel;
    scan_t                scan_end;
    logic                 any_armed;
    logic                 any_after;
    logic                 out_free;
    logic                 roll;
    logic [TIME_BITS-1:0] start;

    assign scan_link[0] = '0;

    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
        tdq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .my_slot   (SLOT_W'(i)),
            .ctl       (ctl),
            .scan_pend (scan_pend_reg),
            .scan_in   (scan_link[i]),
            .scan_out  (scan_link[i+1]),
            .state     (cells[i])
        );
    end

    assign scan_end = scan_link[NUM_SLOTS];
    assign sel      = cells[slot_reg];

    always_comb begin
        any_armed = 1'b0;
        any_after = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            any_armed = any_armed | cells[i].armed;
            any_after = any_after | cells[i].survive;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign roll      = (now_reg < prev_now_reg) &&
                       ((prev_now_reg - now_reg) > TIME_BITS'(window_reg));
    assign start     = fromnow_reg ? now_reg : (sel.deadline - TIME_BITS'(sel.period));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            window_reg   <= ROLLOVER_RESET;
            prev_now_reg <= '0;
            flag_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            prev_now_reg <= prev_now_next;
            flag_reg     <= flag_next;
            if (cfg_valid) begin
                window_reg <= cfg_rollover_window_ms;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg      <= op_t'(s_operation);
            slot_reg    <= SLOT_W'(s_slot_id);
            inrange_reg <= (32'(s_slot_id) < NUM_SLOTS);
            per_reg     <= s_period_ms;
            rec_reg     <= s_recurring;
            fromnow_reg <= s_from_now;
            now_reg     <= TIME_BITS'(s_now_ms);
        end
        cnt_reg       <= cnt_next;
        scan_pend_reg <= scan_pend_next;
        res_ok_reg    <= res_ok_next;
        res_front_reg <= res_front_next;
        res_wait_reg  <= res_wait_next;
        have_prev_reg <= have_prev_next;
        prev_slot_reg <= prev_slot_next;
        any_after_reg <= any_after_next;
        if (out_load) begin
            out_ok_reg    <= out_ok_next;
            out_fired_reg <= out_fired_next;
            out_slot_reg  <= out_slot_next;
            out_wait_reg  <= out_wait_next;
            out_front_reg <= out_front_next;
            out_any_reg   <= out_any_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        prev_now_next  = prev_now_reg;
        flag_next      = flag_reg;
        cnt_next       = cnt_reg;
        scan_pend_next = scan_pend_reg;
        res_ok_next    = res_ok_reg;
        res_front_next = res_front_reg;
        res_wait_next  = res_wait_reg;
        have_prev_next = have_prev_reg;
        prev_slot_next = prev_slot_reg;
        any_after_next = any_after_reg;

        ctl             = '0;
        ctl.slot        = slot_reg;
        ctl.now         = now_reg;
        ctl.roll        = roll;
        ctl.deadline    = sel.deadline;
        ctl.period      = sel.period;
        ctl.repeat_mark = sel.repeat_mark;
        ctl.armed       = sel.armed;

        out_load       = 1'b0;
        out_ok_next    = res_ok_reg;
        out_fired_next = 1'b0;
        out_slot_next  = '0;
        out_wait_next  = res_wait_reg;
        out_front_next = res_front_reg;
        out_any_next   = any_armed;
        out_last_next  = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                res_ok_next    = 1'b0;
                res_front_next = 1'b0;
                res_wait_next  = '0;
                cnt_next       = '0;
                scan_pend_next = 1'b0;
                state_next     = ST_OUT;
                case (op_reg)
                    OP_QUERY: begin
                        res_ok_next = 1'b1;
                        state_next  = ST_SCAN;
                    end
                    OP_EXPIRE: begin
                        res_ok_next = 1'b1;
                        if (any_armed) begin
                            ctl.pend_load  = 1'b1;
                            prev_now_next  = now_reg;
                            have_prev_next = 1'b0;
                            state_next     = ST_XSTART;
                        end
                    end
                    OP_ADD: begin
                        if (inrange_reg) begin
                            ctl.we          = 1'b1;
                            ctl.deadline    = now_reg + TIME_BITS'(per_reg);
                            ctl.period      = per_reg;
                            ctl.repeat_mark = rec_reg;
                            ctl.armed       = 1'b1;
                            res_ok_next     = 1'b1;
                            state_next      = ST_SCAN;
                        end
                    end
                    OP_CANCEL: begin
                        if (inrange_reg) begin
                            ctl.we      = 1'b1;
                            ctl.armed   = 1'b0;
                            res_ok_next = sel.armed;
                        end
                    end
                    OP_REFRESH: begin
                        if (inrange_reg && sel.armed) begin
                            ctl.we       = 1'b1;
                            ctl.deadline = now_reg + TIME_BITS'(sel.period);
                            res_ok_next  = 1'b1;
                        end
                    end
                    OP_RESET: begin
                        if (inrange_reg) begin
                            if ((per_reg == sel.period) && !fromnow_reg) begin
                                res_ok_next = 1'b1;
                            end else if (sel.armed) begin
                                ctl.we       = 1'b1;
                                ctl.period   = per_reg;
                                ctl.deadline = start + TIME_BITS'(per_reg);
                                res_ok_next  = 1'b1;
                                state_next   = ST_SCAN;
                            end
                        end
                    end
                    default: begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end

            // The sequencer waits here while the search wave crosses the row.
            ST_SCAN: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_SLOTS)) begin
                    state_next = ST_OUT;
                    if (op_reg == OP_QUERY) begin
                        flag_next = 1'b0;
                        if (!scan_end.valid) begin
                            res_wait_next = '1;
                        end else if (now_reg >= scan_end.deadline) begin
                            res_wait_next = '0;
                        end else begin
                            res_wait_next = 64'(scan_end.deadline - now_reg);
                        end
                    end else if (scan_end.valid && (scan_end.slot == slot_reg) && !flag_reg) begin
                        res_front_next = 1'b1;
                        flag_next      = 1'b1;
                    end
                end
            end

            ST_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_XSTART: begin
                any_after_next = any_after;
                cnt_next       = '0;
                scan_pend_next = 1'b1;
                state_next     = ST_XSCAN;
            end

            ST_XSCAN: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_SLOTS)) begin
                    state_next = ST_XRES;
                end
            end

            // A found slot is held back one round so that the final one can carry last.
            ST_XRES: begin
                out_ok_next    = 1'b1;
                out_wait_next  = '0;
                out_front_next = 1'b0;
                out_any_next   = any_after_reg;
                out_fired_next = have_prev_reg;
                out_slot_next  = have_prev_reg ? 4'(prev_slot_reg) : 4'd0;
                if (out_free) begin
                    if (scan_end.valid) begin
                        ctl.slot       = scan_end.slot;
                        ctl.pend_clr   = 1'b1;
                        out_load       = have_prev_reg;
                        out_last_next  = 1'b0;
                        have_prev_next = 1'b1;
                        prev_slot_next = scan_end.slot;
                        cnt_next       = '0;
                        state_next     = ST_XSCAN;
                    end else begin
                        ctl.commit    = 1'b1;
                        out_load      = 1'b1;
                        out_last_next = 1'b1;
                        scan_pend_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_ok            = out_ok_reg;
    assign m_fired         = out_fired_reg;
    assign m_fired_slot    = out_slot_reg;
    assign m_wait_ms       = out_wait_reg;
    assign m_front_changed = out_front_reg;
    assign m_any_active    = out_any_reg;
    assign m_last          = out_last_reg;

    `TDQ_ASSERT_SAME(a_fired_ok, m_valid && m_fired, m_ok && !m_front_changed && (m_wait_ms == 64'd0), "fired result carries wrong fields")
    `TDQ_ASSERT_SAME(a_found_pending, (state_reg == ST_XRES) && scan_end.valid, cells[scan_end.slot].pend, "search returned a slot that is not pending")
    `TDQ_ASSERT_NEXT(a_idle_after_load, out_load && out_last_next, state_reg == ST_IDLE, "sequencer busy after final result")

endmodule
